// ===== hw/rtl/mtte_pkg.sv =====
package mtte_pkg;

  // register widths
  localparam int SPC_W     = 25;
  localparam int CNT_REG_W = 4;
  localparam int VOL_W     = 15;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 2;
  localparam int VOL_SHIFT = 14;

  // register reset values
  localparam logic [SPC_W-1:0]     SPACING_RST = 25'd5716253;
  localparam logic [CNT_REG_W-1:0] COUNT_RST   = 4'd3;
  localparam logic [VOL_W-1:0]     VOLUME_RST  = 15'd16384;

  // default geometry
  localparam int DEF_HISTORY_DEPTH = 131072;
  localparam int DEF_MAX_TAPS      = 8;
  localparam int DEF_SAMPLE_BITS   = 16;
  localparam int DEF_FRACTION_BITS = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPACING = 2'd0,
    REG_COUNT   = 2'd1,
    REG_VOLUME  = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_TAP_A,
    ST_TAP_B,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_SCALE,
    ST_MAG,
    ST_RECIP,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/mtte_dmem.sv =====
module mtte_dmem #(
  parameter int DEPTH = mtte_pkg::DEF_HISTORY_DEPTH,
  parameter int DW    = mtte_pkg::DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data
);
  import mtte_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] mem_q_r;
  logic          rd_ok_r;
  logic [AW:0]   fill_r;

  // writes land at 0,1,2,... so everything below the fill level is live;
  // anything above reads as the cleared value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en && (fill_r != (AW+1)'(DEPTH))) begin
        fill_r <= fill_r + 1'b1;
      end
      rd_ok_r <= ({1'b0, rd_addr} < fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    mem_q_r <= mem[rd_addr];
  end

  assign rd_data = rd_ok_r ? mem_q_r : '0;

endmodule

// ===== hw/rtl/mtte_spmod.sv =====
module mtte_spmod #(
  parameter int HISTORY_DEPTH = mtte_pkg::DEF_HISTORY_DEPTH,
  parameter int FRACTION_BITS = mtte_pkg::DEF_FRACTION_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic [mtte_pkg::SPC_W-1:0]               spacing,
  output logic                                     busy,
  output logic [$clog2(HISTORY_DEPTH)+FRACTION_BITS-1:0] residue
);
  import mtte_pkg::*;

  localparam int              PW   = $clog2(HISTORY_DEPTH) + FRACTION_BITS;
  localparam longint unsigned SPAN = longint'(HISTORY_DEPTH) << FRACTION_BITS;
  localparam int              SL   = $clog2(SPAN);
  localparam int              RSH  = SPC_W + SL;
  localparam int              RM_W = SPC_W + 1;
  localparam int              XM_W = SPC_W + RM_W;
  // ceil(2^RSH / span): (x * RM) >> RSH is the exact quotient for any spacing value
  localparam longint unsigned RM   = ((64'd1 << RSH) + SPAN - 1) / SPAN;

  logic [SPC_W-1:0] x_r;
  logic [XM_W-1:0]  xm_r;
  logic [SPC_W-1:0] rem_r;
  logic             step_r;
  logic [SPC_W-1:0] quo;
  logic [SPC_W-1:0] qs;

  // reciprocal product first, then back-multiply and subtract
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 1'b0;
    end else begin
      step_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r  <= spacing;
      xm_r <= XM_W'(spacing) * XM_W'(RM);
    end
    if (step_r) begin
      rem_r <= x_r - qs;
    end
  end

  // quotient times span never exceeds the spacing; a span above it gives quotient 0
  always_comb begin
    quo = SPC_W'(xm_r >> RSH);
    qs  = SPC_W'(quo * SPC_W'(SPAN));
  end

  assign busy    = step_r;
  assign residue = PW'(rem_r);

endmodule

// ===== hw/rtl/multi_tap_tempo_echo_top.sv =====
// Multi-tap echo: write one sample per beat, sum count interpolated taps, scale, divide.
// count = clamped count register; each tap takes two reads on the single memory port.
// One item in flight: no new beat is taken until the last result is loaded out.
// Reset: sync, active low; a fill level masks unwritten entries; input stalls after
// reset and after each spacing write while the spacing residue is recomputed.
module multi_tap_tempo_echo_top #(
  parameter int HISTORY_DEPTH = mtte_pkg::DEF_HISTORY_DEPTH,
  parameter int MAX_TAPS      = mtte_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_BITS   = mtte_pkg::DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = mtte_pkg::DEF_FRACTION_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_in,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_echo_out,
  // configuration
  input  logic                               cfg_we,
  input  logic [mtte_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mtte_pkg::CFG_W-1:0]         cfg_data
);
  import mtte_pkg::*;

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int PW     = AW + FRACTION_BITS;          // tap position, fixed point
  localparam int FW     = FRACTION_BITS + 1;           // fraction weight incl. unity
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int CW     = $clog2(MAX_TAPS);
  localparam int TERM_W = SAMPLE_BITS + FRACTION_BITS + 2;
  localparam int SUM_W  = SAMPLE_BITS + FRACTION_BITS + CW + 2;
  localparam int PROD_W = SUM_W + VOL_W + 1;
  localparam int DSH    = FRACTION_BITS + VOL_SHIFT;
  localparam int Q1_W   = PROD_W - DSH;
  localparam int RS     = Q1_W + CW;                    // reciprocal shift
  localparam int M_W    = RS + 1;
  localparam int QQ_W   = Q1_W + M_W;

  localparam logic [PW:0]          SPAN     = (PW+1)'(HISTORY_DEPTH) << FRACTION_BITS;
  localparam logic [FW-1:0]        ONE      = FW'(1) << FRACTION_BITS;
  localparam logic [AW-1:0]        LAST_A   = AW'(HISTORY_DEPTH - 1);
  localparam logic [Q1_W-1:0]      HALF     = Q1_W'(1) << (SAMPLE_BITS - 1);
  localparam logic [Q1_W-1:0]      SMAX_Q   = HALF - 1'b1;
  localparam logic [SAMPLE_BITS-1:0] SMAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // config registers
  logic [SPC_W-1:0]     spacing_r;
  logic [CNT_REG_W-1:0] count_r;
  logic [VOL_W-1:0]     volume_r;
  logic                 spstart_r;

  // control
  state_t           state_r, state_nxt;
  logic [AW-1:0]    wp_r;
  logic [CNT_W-1:0] kcnt_r;
  logic [CNT_W-1:0] cnt_r;
  logic             mac1_r, mac2_r;
  logic             out_valid_r;

  // datapath
  logic [PW-1:0]                off_r;
  logic [PW-1:0]                pos_r;
  logic [AW-1:0]                b_addr_r;
  logic [FW-1:0]                f_r;
  logic signed [SAMPLE_BITS-1:0] a_val_r;
  logic signed [TERM_W-1:0]     p_r;
  logic signed [SUM_W-1:0]      sum_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic                         neg_r;
  logic [Q1_W-1:0]              q1_r;
  logic [QQ_W-1:0]              qq_r;
  logic [SAMPLE_BITS-1:0]       echo_r;

  // combinational
  logic                         in_acc;
  logic                         out_load;
  logic                         sp_busy;
  logic [PW-1:0]                sm;
  logic [CNT_W-1:0]             cnt_in;
  logic [PW-1:0]                pos_new;
  logic [PW-1:0]                off_new;
  logic [AW-1:0]                tap_a;
  logic [AW-1:0]                tap_b;
  logic [FW-1:0]                tap_f;
  logic [AW-1:0]                rd_addr;
  logic [SAMPLE_BITS-1:0]       rd_data;
  logic [FW-1:0]                w_a;
  logic signed [TERM_W-1:0]     term;
  logic [PROD_W-1:0]            mag;
  logic [Q1_W-1:0]              q;
  logic [SAMPLE_BITS-1:0]       res;
  logic [PW+1:0]                tsum;
  logic [PW:0]                  osum;
  logic [M_W-1:0]               rtab [MAX_TAPS+1];

  // ceil(2^RS / c): exact floor division by c for any q1 below 2^Q1_W
  for (genvar g = 0; g <= MAX_TAPS; g++) begin : g_rtab
    localparam longint unsigned G1 = (g == 0) ? 1 : g;
    localparam longint unsigned RV = (g == 0) ? 0 : ((64'd1 << RS) + G1 - 1) / G1;
    assign rtab[g] = M_W'(RV);
  end

  // delay line storage
  mtte_dmem #(
    .DEPTH (HISTORY_DEPTH),
    .DW    (SAMPLE_BITS)
  ) u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_addr (wp_r),
    .wr_data (in_sample_in),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // spacing mod span, rerun after reset and on every spacing write
  mtte_spmod #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_spmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (spstart_r),
    .spacing (spacing_r),
    .busy    (sp_busy),
    .residue (sm)
  );

  // ---------------- config port ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RST;
      count_r   <= COUNT_RST;
      volume_r  <= VOLUME_RST;
      spstart_r <= 1'b1;
    end else begin
      spstart_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SPACING: begin
            spacing_r <= cfg_data[SPC_W-1:0];
            spstart_r <= 1'b1;
          end
          REG_COUNT:  count_r  <= cfg_data[CNT_REG_W-1:0];
          REG_VOLUME: volume_r <= cfg_data[VOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- tap address math ----------------
  always_comb begin
    // clamp count to the tap budget
    if (32'(count_r) > MAX_TAPS) begin
      cnt_in = CNT_W'(MAX_TAPS);
    end else begin
      cnt_in = CNT_W'(count_r);
    end

    // pos = (wp - offset) mod span, in fixed point
    tsum = ((PW+2)'(wp_r) << FRACTION_BITS) + (PW+2)'(SPAN - {1'b0, off_r});
    if (tsum >= (PW+2)'(SPAN)) begin
      tsum = tsum - (PW+2)'(SPAN);
    end
    pos_new = PW'(tsum);

    // next tap offset = (offset + spacing) mod span
    osum = {1'b0, off_r} + {1'b0, sm};
    if (osum >= SPAN) begin
      osum = osum - SPAN;
    end
    off_new = PW'(osum);

    tap_a = AW'(pos_r >> FRACTION_BITS);
    tap_b = (tap_a == LAST_A) ? '0 : tap_a + 1'b1;
    tap_f = FW'(pos_r) & (ONE - FW'(1));
  end

  // ---------------- interpolation ----------------
  always_comb begin
    w_a  = ONE - f_r;
    term = TERM_W'($signed(a_val_r) * $signed({1'b0, w_a}))
         + TERM_W'($signed(rd_data) * $signed({1'b0, f_r}));
  end

  // ---------------- output scaling ----------------
  always_comb begin
    mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    q   = Q1_W'(qq_r >> RS);
    if (neg_r) begin
      res = (q > HALF) ? SMIN : SAMPLE_BITS'(-q);
    end else begin
      res = (q > SMAX_Q) ? SMAX : SAMPLE_BITS'(q);
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (cnt_in == '0) ? ST_SCALE : ST_POS;
        end
      end
      ST_POS:    state_nxt = ST_TAP_A;
      ST_TAP_A:  state_nxt = ST_TAP_B;
      ST_TAP_B:  state_nxt = (kcnt_r == CNT_W'(1)) ? ST_DRAIN1 : ST_TAP_A;
      ST_DRAIN1: state_nxt = ST_DRAIN2;
      ST_DRAIN2: state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_MAG;
      ST_MAG:    state_nxt = ST_RECIP;
      ST_RECIP:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE) || spstart_r || sp_busy;
    in_acc   = in_valid && !in_stall;
    out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
    // one read port: A side on TAP_A, B side on TAP_B
    rd_addr  = (state_r == ST_TAP_B) ? b_addr_r : tap_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      kcnt_r      <= '0;
      cnt_r       <= '0;
      mac1_r      <= 1'b0;
      mac2_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mac1_r  <= (state_r == ST_TAP_B);   // B data lands next cycle
      mac2_r  <= mac1_r;
      if (in_acc) begin
        kcnt_r <= cnt_in;
        cnt_r  <= cnt_in;
      end else if (state_r == ST_TAP_B) begin
        kcnt_r <= kcnt_r - 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        wp_r        <= (wp_r == LAST_A) ? '0 : wp_r + 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      off_r <= sm;
      sum_r <= '0;
    end
    if ((state_r == ST_POS) || (state_r == ST_TAP_B)) begin
      pos_r <= pos_new;
      off_r <= off_new;
    end
    if (state_r == ST_TAP_A) begin
      b_addr_r <= tap_b;
      f_r      <= tap_f;
    end
    if (state_r == ST_TAP_B) begin
      a_val_r <= $signed(rd_data);
    end
    if (mac1_r) begin
      p_r <= term;
    end
    if (mac2_r) begin
      sum_r <= sum_r + SUM_W'(p_r);
    end
    if (state_r == ST_SCALE) begin
      prod_r <= PROD_W'($signed(sum_r) * $signed({1'b0, volume_r}));
    end
    if (state_r == ST_MAG) begin
      neg_r <= prod_r[PROD_W-1];
      q1_r  <= Q1_W'(mag >> DSH);
    end
    if (state_r == ST_RECIP) begin
      qq_r <= QQ_W'(q1_r * rtab[cnt_r]);
    end
    if (out_load) begin
      echo_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_echo_out = $signed(echo_r);

endmodule
